[hw/rtl/srlm_pkg.sv]
// ----------------------------------------------------------------------------
// Smoothed RMS level meter package
// Shared widths, register codes and the control/status structs between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package srlm_pkg;

  localparam int CHANNELS     = 8;
  localparam int CHANNEL_W    = 3;
  localparam int SAMPLE_W     = 16;
  localparam int LEVEL_W      = 16;
  localparam int SQUARE_W     = 2 * SAMPLE_W;
  localparam int SUM_W        = 41;
  localparam int ALPHA_W      = 16;
  localparam int FRAG_W       = 11;
  localparam int MAX_FRAGMENT = 1024;
  localparam int ONE_Q15      = 32768;
  localparam int MEAN_W       = 31;
  localparam int ROOT_W       = 32;
  localparam int PROD_W       = 2 * LEVEL_W;
  localparam int DIV_CNT_W    = $clog2(SUM_W);

  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 24;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  // Register indexes, taken from paddr[2].
  localparam logic REG_ALPHA    = 1'b0;
  localparam logic REG_FRAG_LEN = 1'b1;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET    = 16'd32768;
  localparam logic [FRAG_W-1:0]  FRAG_LEN_RESET = 11'd64;

  typedef struct packed {
    logic load;       // capture the accepted sample and its square
    logic accum;      // add the square into the channel sum, set up the divider
    logic div_step;   // one quotient bit
    logic root_load;  // clamp the mean and set up the root
    logic root_step;  // two radicand bits
    logic mul_a;      // alpha * rms
    logic mul_b;      // (1 - alpha) * previous level
    logic update;     // store the level, clear the sum, load the output
  } srlm_cmd_t;

  typedef struct packed {
    logic ch_ok;
    logic last;
    logic div_done;
    logic root_done;
    logic out_free;
  } srlm_sts_t;

endpackage

`default_nettype wire

[hw/rtl/srlm_regs.sv]
// ----------------------------------------------------------------------------
// Smoothed RMS level meter configuration registers
// APB register file holding the smoothing weight and the fragment length.
// ----------------------------------------------------------------------------
`default_nettype none

module srlm_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [srlm_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [srlm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [srlm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready,
  output logic      [srlm_pkg::ALPHA_W-1:0]        alpha,
  output logic      [srlm_pkg::FRAG_W-1:0]         fragment_length
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha           <= srlm_pkg::ALPHA_RESET;
      fragment_length <= srlm_pkg::FRAG_LEN_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        srlm_pkg::REG_ALPHA:    alpha <= pwdata[srlm_pkg::ALPHA_W-1:0];
        srlm_pkg::REG_FRAG_LEN: fragment_length <= pwdata[srlm_pkg::FRAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      srlm_pkg::REG_ALPHA:    prdata = srlm_pkg::APB_DATA_W'(alpha);
      srlm_pkg::REG_FRAG_LEN: prdata = srlm_pkg::APB_DATA_W'(fragment_length);
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/srlm_dp.sv]
// ----------------------------------------------------------------------------
// Smoothed RMS level meter datapath
// Per-channel sums and levels, a bit-serial divider, a two-bit-per-cycle
// square root, the smoothing products and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srlm_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire srlm_pkg::srlm_cmd_t                 cmd,
  output srlm_pkg::srlm_sts_t                      sts,
  input  wire logic [srlm_pkg::IN_DATA_W-1:0]      s_tdata,
  input  wire logic                                s_tlast,
  input  wire logic [srlm_pkg::ALPHA_W-1:0]        alpha,
  input  wire logic [srlm_pkg::FRAG_W-1:0]         fragment_length,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [srlm_pkg::OUT_DATA_W-1:0]     m_tdata
);

  // Captured item.
  logic [srlm_pkg::SQUARE_W-1:0]  square;
  logic [srlm_pkg::CHANNEL_W-1:0] ch;
  logic                           last;

  logic [srlm_pkg::SUM_W-1:0]     sums   [srlm_pkg::CHANNELS];
  logic [srlm_pkg::LEVEL_W-1:0]   levels [srlm_pkg::CHANNELS];

  // Divider.
  logic [srlm_pkg::SUM_W-1:0]     div_q;
  logic [srlm_pkg::FRAG_W-1:0]    div_rem;
  logic [srlm_pkg::FRAG_W-1:0]    div_d;
  logic [srlm_pkg::DIV_CNT_W-1:0] div_cnt;

  // Square root.
  logic [srlm_pkg::MEAN_W-1:0]    root_v;
  logic [srlm_pkg::ROOT_W-1:0]    root_res;
  logic [srlm_pkg::MEAN_W-1:0]    root_bit;

  logic [srlm_pkg::PROD_W-1:0]    prod_a;
  logic [srlm_pkg::PROD_W-1:0]    prod_b;

  logic [srlm_pkg::CHANNEL_W-1:0] out_channel;
  logic [srlm_pkg::LEVEL_W-1:0]   level;

  logic [srlm_pkg::SAMPLE_W-1:0]  raw;
  logic [srlm_pkg::SAMPLE_W-1:0]  mag;
  logic [srlm_pkg::SUM_W:0]       sum_add;
  logic [srlm_pkg::SUM_W-1:0]     sum_sat;
  logic [srlm_pkg::FRAG_W-1:0]    len_c;
  logic [srlm_pkg::FRAG_W:0]      rem_sh;
  logic                           rem_ge;
  logic [srlm_pkg::FRAG_W-1:0]    rem_new;
  logic [srlm_pkg::MEAN_W-1:0]    mean_c;
  logic [srlm_pkg::ROOT_W:0]      trial;
  logic                           root_take;
  logic [srlm_pkg::ALPHA_W-1:0]   a_c;
  logic [srlm_pkg::ALPHA_W-1:0]   a_inv;
  logic [srlm_pkg::PROD_W:0]      lvl_sum;
  logic [srlm_pkg::LEVEL_W-1:0]   lvl_c;

  always_comb begin
    raw = s_tdata[srlm_pkg::SAMPLE_W-1:0];
    // The negation of the most negative sample reads as 32768 unsigned.
    mag = raw[srlm_pkg::SAMPLE_W-1] ? (~raw + 1'b1) : raw;

    sum_add = {1'b0, sums[ch]} + (srlm_pkg::SUM_W+1)'(square);
    sum_sat = sum_add[srlm_pkg::SUM_W] ? '1 : sum_add[srlm_pkg::SUM_W-1:0];

    if (fragment_length == '0)
      len_c = srlm_pkg::FRAG_W'(1);
    else if (fragment_length > srlm_pkg::FRAG_W'(srlm_pkg::MAX_FRAGMENT))
      len_c = srlm_pkg::FRAG_W'(srlm_pkg::MAX_FRAGMENT);
    else
      len_c = fragment_length;

    rem_sh  = {div_rem, div_q[srlm_pkg::SUM_W-1]};
    rem_ge  = rem_sh >= {1'b0, div_d};
    rem_new = rem_ge ? srlm_pkg::FRAG_W'(rem_sh - {1'b0, div_d})
                     : rem_sh[srlm_pkg::FRAG_W-1:0];

    if (div_q > srlm_pkg::SUM_W'(2 ** (srlm_pkg::MEAN_W - 1)))
      mean_c = srlm_pkg::MEAN_W'(2 ** (srlm_pkg::MEAN_W - 1));
    else
      mean_c = div_q[srlm_pkg::MEAN_W-1:0];

    trial     = {1'b0, root_res} + (srlm_pkg::ROOT_W+1)'(root_bit);
    root_take = (srlm_pkg::ROOT_W+1)'(root_v) >= trial;

    a_c   = (alpha > srlm_pkg::ALPHA_W'(srlm_pkg::ONE_Q15))
            ? srlm_pkg::ALPHA_W'(srlm_pkg::ONE_Q15) : alpha;
    a_inv = srlm_pkg::ALPHA_W'(srlm_pkg::ONE_Q15) - a_c;

    lvl_sum = {1'b0, prod_a} + {1'b0, prod_b};
    lvl_c   = lvl_sum[srlm_pkg::LEVEL_W+14:15];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      square <= srlm_pkg::SQUARE_W'(mag) * srlm_pkg::SQUARE_W'(mag);
      ch     <= s_tdata[srlm_pkg::SAMPLE_W +: srlm_pkg::CHANNEL_W];
      last   <= s_tlast;
    end
    if (cmd.accum) begin
      div_q   <= sum_sat;
      div_rem <= '0;
      div_d   <= len_c;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      div_q   <= {div_q[srlm_pkg::SUM_W-2:0], rem_ge};
      div_rem <= rem_new;
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.root_load) begin
      root_v   <= mean_c;
      root_res <= '0;
      root_bit <= srlm_pkg::MEAN_W'(2 ** (srlm_pkg::MEAN_W - 1));
    end
    if (cmd.root_step) begin
      if (root_take) begin
        root_v   <= root_v - trial[srlm_pkg::MEAN_W-1:0];
        root_res <= (root_res >> 1) + srlm_pkg::ROOT_W'(root_bit);
      end else begin
        root_res <= root_res >> 1;
      end
      root_bit <= root_bit >> 2;
    end
    if (cmd.mul_a) begin
      prod_a <= srlm_pkg::PROD_W'(a_c) * srlm_pkg::PROD_W'(root_res[srlm_pkg::LEVEL_W-1:0]);
    end
    if (cmd.mul_b) begin
      prod_b <= srlm_pkg::PROD_W'(a_inv) * srlm_pkg::PROD_W'(levels[ch]);
    end
    if (cmd.update) begin
      out_channel <= ch;
      level       <= lvl_c;
    end
  end

  // Channel state; reset to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < srlm_pkg::CHANNELS; i++) begin
        sums[i]   <= '0;
        levels[i] <= '0;
      end
    end else begin
      if (cmd.accum && sts.ch_ok) begin
        sums[ch] <= sum_sat;
      end
      if (cmd.update) begin
        sums[ch]   <= '0;
        levels[ch] <= lvl_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.update) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {{(srlm_pkg::OUT_DATA_W - srlm_pkg::LEVEL_W - srlm_pkg::CHANNEL_W){1'b0}},
                    level, out_channel};

  assign sts.ch_ok     = 32'(ch) < srlm_pkg::CHANNELS;
  assign sts.last      = last;
  assign sts.div_done  = div_cnt == srlm_pkg::DIV_CNT_W'(srlm_pkg::SUM_W - 1);
  assign sts.root_done = root_bit[0];
  assign sts.out_free  = !m_tvalid || m_tready;

endmodule

`default_nettype wire

[hw/rtl/srlm_ctrl.sv]
// ----------------------------------------------------------------------------
// Smoothed RMS level meter controller
// Sequences accumulate, divide, square root, smoothing and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module srlm_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire srlm_pkg::srlm_sts_t   sts,
  output srlm_pkg::srlm_cmd_t        cmd
);

  typedef enum logic [2:0] {
    IDLE,
    ACCUM,
    DIVIDE,
    ROOT_LOAD,
    ROOT,
    MUL_A,
    MUL_B,
    UPDATE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE:      if (s_tvalid) state <= ACCUM;
        ACCUM:     state <= (sts.ch_ok && sts.last) ? DIVIDE : IDLE;
        DIVIDE:    if (sts.div_done) state <= ROOT_LOAD;
        ROOT_LOAD: state <= ROOT;
        ROOT:      if (sts.root_done) state <= MUL_A;
        MUL_A:     state <= MUL_B;
        MUL_B:     state <= UPDATE;
        UPDATE:    if (sts.out_free) state <= IDLE;
        default:   state <= IDLE;
      endcase
    end
  end

  assign s_tready = (state == IDLE);

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == IDLE) && s_tvalid;
    cmd.accum     = (state == ACCUM);
    cmd.div_step  = (state == DIVIDE);
    cmd.root_load = (state == ROOT_LOAD);
    cmd.root_step = (state == ROOT);
    cmd.mul_a     = (state == MUL_A);
    cmd.mul_b     = (state == MUL_B);
    // The level is committed only once the output register can take it.
    cmd.update    = (state == UPDATE) && sts.out_free;
  end

endmodule

`default_nettype wire

[hw/rtl/smoothed_rms_level_meter.sv]
// ----------------------------------------------------------------------------
// Smoothed RMS level meter
// Per-channel sum of squares; on a fragment end the mean square is divided,
// rooted, exponentially smoothed and reported.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  s_        tvalid/tready      tdata: sample[15:0], channel[18:16]; tlast: fragment_end
//  m_        tvalid/tready      tdata: out_channel[2:0], level[18:3]
//  APB       psel/penable       regs: alpha at 0x0, fragment_length at 0x4
//
// A sample without the fragment end flag is accepted, then accumulated.
// A fragment end then adds the bit-serial divide, the square root, the two
// smoothing multiplies and the update, in that order.
// A result waiting in the output register stalls only the next fragment end.
// Reset is synchronous and clears all channel sums and levels.
// ----------------------------------------------------------------------------
`default_nettype none

module smoothed_rms_level_meter (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [srlm_pkg::IN_DATA_W-1:0]      s_tdata,   // sample, channel
  input  wire logic                                s_tlast,   // fragment_end
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [srlm_pkg::OUT_DATA_W-1:0]     m_tdata,   // out_channel, level
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [srlm_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [srlm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [srlm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready
);

  logic [srlm_pkg::ALPHA_W-1:0] alpha;
  logic [srlm_pkg::FRAG_W-1:0]  fragment_length;
  srlm_pkg::srlm_cmd_t          cmd;
  srlm_pkg::srlm_sts_t          sts;

  srlm_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .alpha           (alpha),
    .fragment_length (fragment_length)
  );

  srlm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srlm_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .alpha           (alpha),
    .fragment_length (fragment_length),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata)
  );

endmodule

`default_nettype wire

[hw/rtl/srlm_checker.sv]
// ----------------------------------------------------------------------------
// Smoothed RMS level meter checker
// Port-level properties of the meter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module srlm_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               s_tvalid,
  input wire logic                               s_tready,
  input wire logic                               m_tvalid,
  input wire logic                               m_tready,
  input wire logic [srlm_pkg::OUT_DATA_W-1:0]    m_tdata,
  input wire logic                               pready
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The smoothed level never exceeds one in Q1.15.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[18:3] <= 16'd32768)
    else $error("level above full scale");

  // Each accepted sample occupies the block, so two samples are never accepted back to back.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("sample accepted on consecutive cycles");

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

endmodule

bind smoothed_rms_level_meter srlm_checker u_chk (.*);

`default_nettype wire
